// ===== rtl/plu_pkg.sv =====
// Shared constants, codes and types of the positional list unit.
`timescale 1ns / 1ps
package plu_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 16;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DEL,
    S_DUMP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/plu_in_if.sv =====
// Command channel: operation kind, list position and value.
`timescale 1ns / 1ps
interface plu_in_if
  import plu_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

// ===== rtl/plu_out_if.sv =====
// Response channel: status, dumped entry, last mark and list size.
`timescale 1ns / 1ps
interface plu_out_if
  import plu_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] entry_value;
  logic                     last;
  logic [SIZE_W-1:0]        size;

  modport source (output valid, status, entry_value, last, size, input ready);
  modport sink   (input valid, status, entry_value, last, size, output ready);
endinterface

// ===== rtl/plu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module plu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/positional_list_insert_delete_unit.sv =====
// Positional list unit: an ordered list of up to CAPACITY signed 32-bit values held packed
// from the front in one RAM. An insert or delete answers with one response. When nothing
// has to move (append, removal of the tail, or any refused operation), the command goes
// straight to the response state. Otherwise the entries behind the position are shifted
// through the RAM one per cycle (read one entry, write it to its neighbor), and an insert
// then writes the value in one more step before its response.
// A dump answers with one response per entry, front first, the final one marked last.
// The first entry loads once the read of the front entry, issued when the command is taken,
// is marked valid in S_DUMP, and the rest follow one per cycle while the output is not
// stalled. An empty list answers with a single response of status "list empty". A new
// command is taken only once the previous one is finished, while its final response may
// still wait in the output register.
`timescale 1ns / 1ps
module positional_list_insert_delete_unit
  import plu_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic      clk,
  input logic      rst,
  plu_in_if.sink   cmd,
  plu_out_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

  state_t                   state, state_next;
  logic [AW-1:0]            idx, idx_next;
  logic [AW-1:0]            pos_r, pos_r_next;
  logic signed [DATA_W-1:0] val_r, val_r_next;
  logic [CW-1:0]            count, count_next;
  logic [STAT_W-1:0]        res_status, res_status_next;
  logic                     rd_ok, rd_ok_next;

  logic                     rsp_valid;
  logic [STAT_W-1:0]        rsp_status;
  logic signed [DATA_W-1:0] rsp_value;
  logic                     rsp_last;
  logic [SIZE_W-1:0]        rsp_size;

  logic                     load;
  logic [STAT_W-1:0]        ld_status;
  logic signed [DATA_W-1:0] ld_value;
  logic                     ld_last;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic                     slot_free;
  logic                     accept;
  logic [POS_W+CW-1:0]      pos_ext;
  logic [POS_W+CW-1:0]      cnt_ext;
  logic [CW-1:0]            idx_cnt;
  logic [CW-1:0]            cnt_minus1;
  logic [SIZE_W+CW-1:0]     size_ext;

  plu_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign slot_free  = !rsp_valid || rsp.ready;
  assign cmd.ready  = (state == S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign pos_ext    = {{CW{1'b0}}, cmd.position};
  assign cnt_ext    = {{POS_W{1'b0}}, count};
  assign idx_cnt    = CW'(idx);
  assign cnt_minus1 = count - CNT_ONE;
  assign size_ext   = {{SIZE_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_ok <= rd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pos_r      <= pos_r_next;
    val_r      <= val_r_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    pos_r_next      = pos_r;
    val_r_next      = val_r;
    count_next      = count;
    res_status_next = res_status;
    rd_ok_next      = rd_ok;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = ram_rdata;
    ram_raddr       = idx;
    load            = 1'b0;
    ld_status       = STAT_OK;
    ld_value        = '0;
    ld_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.kind)
            KIND_INSERT: begin
              if (count >= CNT_CAP) begin
                res_status_next = STAT_FULL;
                state_next      = S_DONE;
              end else if (pos_ext >= cnt_ext) begin
                // append at the tail, nothing moves
                ram_we          = 1'b1;
                ram_waddr       = count[AW-1:0];
                ram_wdata       = cmd.value;
                count_next      = count + CNT_ONE;
                res_status_next = STAT_OK;
                state_next      = S_DONE;
              end else begin
                pos_r_next = cmd.position[AW-1:0];
                val_r_next = cmd.value;
                idx_next   = count[AW-1:0];
                ram_raddr  = cnt_minus1[AW-1:0];
                state_next = S_INS;
              end
            end
            KIND_DELETE: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
                state_next      = S_DONE;
              end else if (pos_ext >= cnt_ext) begin
                res_status_next = STAT_BADPOS;
                state_next      = S_DONE;
              end else if (cmd.position[AW-1:0] == cnt_minus1[AW-1:0]) begin
                // drop the tail, nothing moves
                count_next      = cnt_minus1;
                res_status_next = STAT_OK;
                state_next      = S_DONE;
              end else begin
                idx_next   = cmd.position[AW-1:0];
                ram_raddr  = cmd.position[AW-1:0] + AW'(1);
                state_next = S_DEL;
              end
            end
            KIND_DUMP: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
                state_next      = S_DONE;
              end else begin
                idx_next   = '0;
                ram_raddr  = '0;
                rd_ok_next = 1'b0;
                state_next = S_DUMP;
              end
            end
            default: begin
              res_status_next = STAT_OK;
              state_next      = S_DONE;
            end
          endcase
        end
      end

      S_INS: begin
        // move entry idx-1 back to idx, walking toward the insert position
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (idx == pos_r + AW'(1)) begin
          state_next = S_INS_LAST;
        end else begin
          idx_next  = idx - AW'(1);
          ram_raddr = idx - AW'(2);
        end
      end

      S_INS_LAST: begin
        ram_we          = 1'b1;
        ram_waddr       = pos_r;
        ram_wdata       = val_r;
        count_next      = count + CNT_ONE;
        res_status_next = STAT_OK;
        state_next      = S_DONE;
      end

      S_DEL: begin
        // move entry idx+1 forward to idx, walking toward the tail
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (idx_cnt + CNT_ONE == cnt_minus1) begin
          count_next      = cnt_minus1;
          res_status_next = STAT_OK;
          state_next      = S_DONE;
        end else begin
          idx_next  = idx + AW'(1);
          ram_raddr = idx + AW'(2);
        end
      end

      S_DUMP: begin
        rd_ok_next = 1'b1;
        if (rd_ok && slot_free) begin
          load      = 1'b1;
          ld_status = STAT_OK;
          ld_value  = ram_rdata;
          ld_last   = (idx_cnt == cnt_minus1);
          if (idx_cnt == cnt_minus1) begin
            state_next = S_IDLE;
          end else begin
            idx_next  = idx + AW'(1);
            ram_raddr = idx + AW'(1);
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_status  = res_status;
          ld_value   = '0;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status <= ld_status;
      rsp_value  <= ld_value;
      rsp_last   <= ld_last;
      rsp_size   <= size_ext[SIZE_W-1:0];
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_value = rsp_value;
  assign rsp.last        = rsp_last;
  assign rsp.size        = rsp_size;

endmodule
